@@ hdl/pidw_pkg.sv @@
// ----------------------------------------------------------------------------
// pidw_pkg
// Shared types, widths, register indexes and clamp helpers for the PID loop.
// ----------------------------------------------------------------------------
package pidw_pkg;

  localparam int unsigned DVD_W = 49;  // divider dividend and quotient width
  localparam int unsigned DVS_W = 33;  // divider divisor and remainder width

  localparam logic [2:0] REG_GAIN_P      = 3'd0;
  localparam logic [2:0] REG_GAIN_I      = 3'd1;
  localparam logic [2:0] REG_GAIN_D      = 3'd2;
  localparam logic [2:0] REG_WRAP_ENABLE = 3'd3;
  localparam logic [2:0] REG_WRAP_LOW    = 3'd4;
  localparam logic [2:0] REG_WRAP_HIGH   = 3'd5;

  localparam logic [31:0] Q_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] Q_MIN = 32'h8000_0000;

  typedef struct packed {
    logic              action;
    logic signed [31:0] target;
    logic signed [31:0] measured;
    logic [31:0]        elapsed;
  } pidw_in_t;

  typedef struct packed {
    logic signed [31:0] drive;
    logic               saturated;
  } pidw_out_t;

  typedef struct packed {
    logic        clip;
    logic [31:0] val;
  } clip32_t;

  typedef struct packed {
    logic        clip;
    logic [47:0] val;
  } clip48_t;

  function automatic clip32_t clip32(input logic signed [50:0] x);
    clip32_t r;
    r.clip = 1'b0;
    r.val  = x[31:0];
    if (x > 51'sd2147483647) begin
      r.clip = 1'b1;
      r.val  = Q_MAX;
    end else if (x < -51'sd2147483648) begin
      r.clip = 1'b1;
      r.val  = Q_MIN;
    end
    return r;
  endfunction

  function automatic clip48_t clip48(input logic signed [50:0] x);
    clip48_t r;
    r.clip = 1'b0;
    r.val  = x[47:0];
    if (x > 51'sd140737488355327) begin
      r.clip = 1'b1;
      r.val  = 48'h7FFF_FFFF_FFFF;
    end else if (x < -51'sd140737488355328) begin
      r.clip = 1'b1;
      r.val  = 48'h8000_0000_0000;
    end
    return r;
  endfunction

endpackage

@@ hdl/pidw_div.sv @@
// ----------------------------------------------------------------------------
// pidw_div
// Restoring unsigned divider, one quotient bit per cycle, done pulse at end.
// ----------------------------------------------------------------------------
module pidw_div
  import pidw_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient,
  output logic [DVS_W-1:0] remainder
);

  localparam int unsigned CNT_W = $clog2(DVD_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DVD_W - 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [DVD_W-1:0] quo_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [DVS_W:0]   trial;
  logic [DVS_W:0]   diff;
  logic             take;

  always_comb begin
    trial = {rem_r, quo_r[DVD_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        quo_r <= {quo_r[DVD_W-2:0], take};
        rem_r <= take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

@@ hdl/pid_with_wrapped_error.sv @@
// ----------------------------------------------------------------------------
// pid_with_wrapped_error
// PID loop in signed Q16.16 with optional circular error and trapezoidal
// integral, run by a small sequencer over one multiplier and one divider.
// ----------------------------------------------------------------------------
//  channel   handshake              payload
//  in        in_valid / in_ready    in_data  (action, target, measured, elapsed)
//  out       out_valid / out_ready  out_data (drive, saturated)
//  cfg       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  A start item gives no result. An update item raises out_valid after ST_ERR,
//  P multiply, D divider run and multiply (if elapsed time is nonzero), slice
//  and I multiplies and ST_SUM; folding the measurement runs ST_WDIV first.
//  A divider run is a load and 49 bit steps; a multiply is MLO, MHI, MFIN.
//  in_ready is high only when idle. The result holds until out_ready.
//  Synchronous active-low reset clears gains, integral and previous error.
// ----------------------------------------------------------------------------
module pid_with_wrapped_error
  import pidw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  pidw_in_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output pidw_out_t   out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_WDIV = 4'd1;
  localparam logic [3:0] ST_ERR  = 4'd2;
  localparam logic [3:0] ST_MLO  = 4'd3;
  localparam logic [3:0] ST_MHI  = 4'd4;
  localparam logic [3:0] ST_MFIN = 4'd5;
  localparam logic [3:0] ST_DDIV = 4'd6;
  localparam logic [3:0] ST_ILD  = 4'd7;
  localparam logic [3:0] ST_SUM  = 4'd8;
  localparam logic [3:0] ST_OUT  = 4'd9;

  localparam logic [1:0] T_P = 2'd0;
  localparam logic [1:0] T_D = 2'd1;
  localparam logic [1:0] T_S = 2'd2;
  localparam logic [1:0] T_I = 2'd3;

  logic [3:0] state_r;
  logic [1:0] term_r;

  logic signed [31:0] gain_p_r, gain_i_r, gain_d_r, wrap_low_r, wrap_high_r;
  logic               wrap_en_r;
  logic signed [47:0] integ_r;
  logic signed [31:0] prev_r;

  logic signed [31:0] t_r;
  logic [31:0]        el_r;
  logic signed [33:0] w_r;
  logic               wrap_r;
  logic               fold_neg_r;
  logic signed [31:0] err_r;
  logic signed [32:0] derr_r;
  logic signed [31:0] p_r, d_r, i_r;
  logic               sat_r;
  pidw_out_t          out_r;

  logic [48:0] a_r;
  logic [31:0] b_r;
  logic        neg_r;
  logic [63:0] lo_r;
  logic [48:0] hi_r;

  // divider
  logic             div_start;
  logic [DVD_W-1:0] div_dvd;
  logic [DVS_W-1:0] div_dvs;
  logic             div_done;
  logic [DVD_W-1:0] div_quo;
  logic [DVS_W-1:0] div_rem;

  pidw_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (div_dvd),
    .divisor   (div_dvs),
    .done      (div_done),
    .quotient  (div_quo),
    .remainder (div_rem)
  );

  logic               in_fire;
  logic signed [32:0] in_t33, in_m33, wh33, wl33;
  logic               wrap_on, m_above, m_below;
  logic [32:0]        derr_mag;

  always_comb begin
    in_fire  = in_valid && in_ready;
    in_t33   = 33'(in_data.target);
    in_m33   = 33'(in_data.measured);
    wh33     = 33'(wrap_high_r);
    wl33     = 33'(wrap_low_r);
    wrap_on  = wrap_en_r && (wrap_high_r > wrap_low_r);
    m_above  = in_data.measured > wrap_high_r;
    m_below  = in_data.measured < wrap_low_r;
    derr_mag = derr_r[32] ? 33'(-derr_r) : 33'(derr_r);
    div_start = 1'b0;
    div_dvd   = {16'd0, 33'(wh33 - wl33)};
    div_dvs   = 33'(wh33 - wl33);
    if (state_r == ST_IDLE) begin
      div_start = in_fire && in_data.action && wrap_on && (m_above || m_below);
      div_dvd   = m_above ? {16'd0, 33'(in_m33 - wh33)} : {16'd0, 33'(wl33 - in_m33)};
    end else begin
      div_start = (state_r == ST_MFIN) && (term_r == T_P) && (el_r != 32'd0);
      div_dvd   = {derr_mag, 16'd0};
      div_dvs   = {1'b0, el_r};
    end
  end

  // shared multiplier
  logic [31:0] mul_a;
  logic [63:0] mul_p;

  always_comb begin
    mul_a = (state_r == ST_MHI) ? {15'd0, a_r[48:32]} : a_r[31:0];
    mul_p = mul_a * b_r;
  end

  // error path
  logic signed [35:0] tx, wx, whx, wlx, e1, e2, e1m, e2m, esel;
  clip32_t            err_c;
  logic signed [31:0] err_v;
  logic [31:0]        err_mag;

  always_comb begin
    tx   = 36'(t_r);
    wx   = 36'(w_r);
    whx  = 36'(wrap_high_r);
    wlx  = 36'(wrap_low_r);
    e1   = tx - wx;
    e2   = (tx > wx) ? ((tx - whx) + (wlx - wx)) : ((whx - wx) + (tx - wlx));
    e1m  = e1[35] ? -e1 : e1;
    e2m  = e2[35] ? -e2 : e2;
    esel = (wrap_r && (e2m < e1m)) ? e2 : e1;
    err_c   = clip32(51'(esel));
    err_v   = err_c.val;
    err_mag = err_v[31] ? 32'(-err_v) : 32'(err_v);
  end

  // product finish
  logic [80:0]        full, rnd16, rnd17;
  logic [64:0]        qpos, lim;
  logic [49:0]        smag;
  logic [31:0]        gres;
  logic               gclip;
  logic signed [50:0] isum;
  clip48_t            integ_c;

  always_comb begin
    full  = {hi_r, 32'd0} + {17'd0, lo_r};
    rnd16 = full + 81'h0FFFF;
    rnd17 = full + 81'h1FFFF;
    qpos  = full[80:16];
    lim   = rnd16[80:16];
    gclip = 1'b0;
    if (!neg_r) begin
      if (qpos > 65'd2147483647) begin
        gclip = 1'b1;
        gres  = Q_MAX;
      end else begin
        gres = qpos[31:0];
      end
    end else begin
      if (lim > 65'd2147483648) begin
        gclip = 1'b1;
        gres  = Q_MIN;
      end else begin
        gres = 32'd0 - lim[31:0];
      end
    end
    smag    = neg_r ? rnd17[66:17] : full[66:17];
    isum    = neg_r ? (51'(integ_r) - 51'({1'b0, smag}))
                    : (51'(integ_r) + 51'({1'b0, smag}));
    integ_c = clip48(isum);
  end

  // slice operands
  logic signed [32:0] s33;
  logic [32:0]        s_mag;
  clip32_t            tot_c;
  clip32_t            start_c;

  always_comb begin
    s33     = 33'(prev_r) + 33'(err_r);
    s_mag   = s33[32] ? 33'(-s33) : 33'(s33);
    tot_c   = clip32(51'(p_r) + 51'(i_r) + 51'(d_r));
    start_c = clip32(51'(in_t33 - in_m33));
  end

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      term_r      <= T_P;
      gain_p_r    <= '0;
      gain_i_r    <= '0;
      gain_d_r    <= '0;
      wrap_en_r   <= 1'b0;
      wrap_low_r  <= '0;
      wrap_high_r <= '0;
      integ_r     <= '0;
      prev_r      <= '0;
      sat_r       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_GAIN_P:      gain_p_r    <= cfg_data;
          REG_GAIN_I:      gain_i_r    <= cfg_data;
          REG_GAIN_D:      gain_d_r    <= cfg_data;
          REG_WRAP_ENABLE: wrap_en_r   <= cfg_data[0];
          REG_WRAP_LOW:    wrap_low_r  <= cfg_data;
          REG_WRAP_HIGH:   wrap_high_r <= cfg_data;
          default: ;
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (!in_data.action) begin
              integ_r <= '0;
              prev_r  <= start_c.val;
            end else begin
              t_r        <= in_data.target;
              el_r       <= in_data.elapsed;
              w_r        <= 34'(in_data.measured);
              wrap_r     <= wrap_on;
              fold_neg_r <= !m_above;
              sat_r      <= 1'b0;
              state_r    <= div_start ? ST_WDIV : ST_ERR;
            end
          end
        end
        ST_WDIV: begin
          if (div_done) begin
            w_r     <= fold_neg_r ? (34'(wrap_high_r) - 34'(div_rem))
                                  : (34'(wrap_low_r) + 34'(div_rem));
            state_r <= ST_ERR;
          end
        end
        ST_ERR: begin
          err_r   <= err_v;
          derr_r  <= 33'(err_v) - 33'(prev_r);
          sat_r   <= sat_r | err_c.clip;
          a_r     <= 49'(err_mag);
          b_r     <= gain_p_r[31] ? 32'(-gain_p_r) : 32'(gain_p_r);
          neg_r   <= err_v[31] ^ gain_p_r[31];
          term_r  <= T_P;
          state_r <= ST_MLO;
        end
        ST_MLO: begin
          lo_r    <= mul_p;
          state_r <= ST_MHI;
        end
        ST_MHI: begin
          hi_r    <= mul_p[48:0];
          state_r <= ST_MFIN;
        end
        ST_MFIN: begin
          unique case (term_r)
            T_P: begin
              p_r <= gres;
              if (el_r != 32'd0) begin
                sat_r   <= sat_r | gclip;
                state_r <= ST_DDIV;
              end else begin
                if (derr_r == 33'sd0 || gain_d_r == 32'sd0) begin
                  d_r   <= '0;
                  sat_r <= sat_r | gclip;
                end else begin
                  sat_r <= 1'b1;
                  d_r   <= (derr_r[32] != gain_d_r[31]) ? Q_MIN : Q_MAX;
                end
                a_r     <= 49'(s_mag);
                b_r     <= el_r;
                neg_r   <= s33[32];
                term_r  <= T_S;
                state_r <= ST_MLO;
              end
            end
            T_D: begin
              d_r     <= gres;
              sat_r   <= sat_r | gclip;
              a_r     <= 49'(s_mag);
              b_r     <= el_r;
              neg_r   <= s33[32];
              term_r  <= T_S;
              state_r <= ST_MLO;
            end
            T_S: begin
              integ_r <= integ_c.val;
              sat_r   <= sat_r | integ_c.clip;
              prev_r  <= err_r;
              state_r <= ST_ILD;
            end
            T_I: begin
              i_r     <= gres;
              sat_r   <= sat_r | gclip;
              state_r <= ST_SUM;
            end
            default: ;
          endcase
        end
        ST_DDIV: begin
          if (div_done) begin
            a_r     <= div_quo;
            b_r     <= gain_d_r[31] ? 32'(-gain_d_r) : 32'(gain_d_r);
            neg_r   <= derr_r[32] ^ gain_d_r[31];
            term_r  <= T_D;
            state_r <= ST_MLO;
          end
        end
        ST_ILD: begin
          a_r     <= integ_r[47] ? 49'(-50'(integ_r)) : 49'(integ_r);
          b_r     <= gain_i_r[31] ? 32'(-gain_i_r) : 32'(gain_i_r);
          neg_r   <= integ_r[47] ^ gain_i_r[31];
          term_r  <= T_I;
          state_r <= ST_MLO;
        end
        ST_SUM: begin
          out_r.drive     <= tot_c.val;
          out_r.saturated <= sat_r | tot_c.clip;
          state_r         <= ST_OUT;
        end
        ST_OUT: begin
          if (out_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule
